// ----- hdl/tsag_pkg.sv -----
// Shared types, constants and arithmetic helpers for the tempo-synced audio gate.
package tsag_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_W      = 25;
  localparam int GAIN_FRAC   = 24;
  localparam int WET_W       = 17;
  localparam int WET_FRAC    = 16;
  localparam int PHASE_W     = 32;
  localparam int STEP_W      = 24;
  localparam int RATE_W      = 3;
  localparam int CFG_DATA_W  = 25;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [WET_W-1:0]  WET_FULL   = WET_W'(1) << WET_FRAC;

  localparam logic [STEP_W-1:0] BEAT_STEP_RESET = STEP_W'(178957);
  localparam logic [RATE_W-1:0] RATE_RESET      = RATE_W'(2);
  localparam logic [GAIN_W-1:0] SLEW_RESET      = GAIN_W'(33490);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEAT_STEP = 3'd0,
    REG_RATE_MODE = 3'd1,
    REG_RISE_STEP = 3'd2,
    REG_FALL_STEP = 3'd3,
    REG_WET       = 3'd4,
    REG_DIP_FIRST = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [STEP_W-1:0] beat_phase_step;
    logic [RATE_W-1:0] rate_mode;
    logic [GAIN_W-1:0] rise_step;
    logic [GAIN_W-1:0] fall_step;
    logic [WET_W-1:0]  wet_amount;
    logic              dip_first;
  } cfg_t;

  // One accepted sample pair together with the gain that applies to it.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [GAIN_W-1:0]             gain;
  } mid_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } out_t;

  // Floor the product with the Q1.24 gain back to sample scale and saturate.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [PROD_W-1:0] p);
    logic signed [SAMPLE_BITS+1:0] q;
    logic signed [SAMPLE_BITS+1:0] q_max;
    logic signed [SAMPLE_BITS+1:0] q_min;
    logic signed [SAMPLE_BITS-1:0] r;
    q     = $signed(p[PROD_W-1:GAIN_FRAC]);
    q_max = $signed({3'b000, {(SAMPLE_BITS-1){1'b1}}});
    q_min = $signed({3'b111, {(SAMPLE_BITS-1){1'b0}}});
    if (q > q_max) begin
      r = q_max[SAMPLE_BITS-1:0];
    end else if (q < q_min) begin
      r = q_min[SAMPLE_BITS-1:0];
    end else begin
      r = q[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/tsag_front.sv -----
// Front end: accepts sample pairs, advances the gate phase and slews the gain.
module tsag_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tsag_pkg::cfg_t                         cfg,
  input  logic                                   push,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_sample,
  input  logic                                   q_full,
  output logic                                   q_push,
  output tsag_pkg::mid_t                         q_data
);

  logic [tsag_pkg::PHASE_W-1:0] phase;
  logic [tsag_pkg::PHASE_W-1:0] phase_next;
  logic [tsag_pkg::GAIN_W-1:0]  gain;
  logic [tsag_pkg::GAIN_W-1:0]  gain_next;
  logic [tsag_pkg::GAIN_W-1:0]  target;
  logic [tsag_pkg::GAIN_W:0]    rise_sum;
  logic [tsag_pkg::GAIN_W-1:0]  excess;
  logic [tsag_pkg::PHASE_W-1:0] step_base;
  logic [1:0]                   shift;
  logic                         active;
  logic                         target_high;
  logic                         accept;

  assign accept = push && !q_full;

  always_comb begin
    active      = (cfg.rate_mode >= tsag_pkg::RATE_W'(1)) &&
                  (cfg.rate_mode <= tsag_pkg::RATE_W'(4));
    // The first half of the gate cycle is the one with the phase MSB clear.
    target_high = active ? (cfg.dip_first ? phase[tsag_pkg::PHASE_W-1]
                                          : !phase[tsag_pkg::PHASE_W-1])
                         : 1'b1;
    target      = target_high ? tsag_pkg::UNITY_GAIN : '0;

    rise_sum = {1'b0, gain} + {1'b0, cfg.rise_step};
    excess   = gain - target;
    gain_next = gain;
    if (gain < target) begin
      gain_next = (rise_sum > {1'b0, target}) ? target : rise_sum[tsag_pkg::GAIN_W-1:0];
    end else if (gain > target) begin
      gain_next = (excess <= cfg.fall_step) ? target : gain - cfg.fall_step;
    end

    step_base  = {{(tsag_pkg::PHASE_W-tsag_pkg::STEP_W){1'b0}}, cfg.beat_phase_step};
    shift      = 2'(cfg.rate_mode - tsag_pkg::RATE_W'(1));
    phase_next = active ? phase + (step_base << shift) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      gain  <= tsag_pkg::UNITY_GAIN;
    end else if (accept) begin
      phase <= phase_next;
      gain  <= gain_next;
    end
  end

  assign q_push       = accept;
  assign q_data.left  = left_sample;
  assign q_data.right = right_sample;
  assign q_data.gain  = gain_next;

endmodule

// ----- hdl/tsag_queue.sv -----
// Two-entry queue that decouples the front end from the gain multipliers.
module tsag_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsag_pkg::mid_t push_data,
  output logic           full,
  input  logic           pop,
  output tsag_pkg::mid_t pop_data,
  output logic           empty
);

  tsag_pkg::mid_t               mem [tsag_pkg::QUEUE_DEPTH];
  logic [tsag_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tsag_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tsag_pkg::QCNT_W-1:0]  count;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count == tsag_pkg::QCNT_W'(tsag_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr];

endmodule

// ----- hdl/tsag_back.sv -----
// Back end: attenuation and channel multipliers followed by the result queue.
module tsag_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [tsag_pkg::WET_W-1:0]              wet_amount,
  input  logic                                    q_empty,
  input  tsag_pkg::mid_t                          q_data,
  output logic                                    q_pop,
  input  logic                                    pop,
  output logic                                    empty,
  output logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_out
);

  localparam int ATTEN_PROD_W = tsag_pkg::WET_W + tsag_pkg::GAIN_W;

  // Stage one holds the attenuation, stage two the channel products.
  logic                                    v1;
  logic                                    v2;
  logic signed [tsag_pkg::SAMPLE_BITS-1:0] s1_left;
  logic signed [tsag_pkg::SAMPLE_BITS-1:0] s1_right;
  logic [tsag_pkg::GAIN_W-1:0]             s1_atten;
  logic signed [tsag_pkg::PROD_W-1:0]      s2_left;
  logic signed [tsag_pkg::PROD_W-1:0]      s2_right;

  logic [tsag_pkg::WET_W-1:0]   wet_c;
  logic [tsag_pkg::GAIN_W-1:0]  gain_def;
  logic [ATTEN_PROD_W-1:0]      atten_prod;
  logic [tsag_pkg::GAIN_W-1:0]  factor;
  logic                         adv;

  tsag_pkg::out_t               oq_mem [tsag_pkg::QUEUE_DEPTH];
  tsag_pkg::out_t               oq_in;
  logic [tsag_pkg::QPTR_W-1:0]  oq_wr;
  logic [tsag_pkg::QPTR_W-1:0]  oq_rd;
  logic [tsag_pkg::QCNT_W-1:0]  oq_count;
  logic                         oq_full;
  logic                         oq_push;
  logic                         oq_pop;

  assign oq_full = (oq_count == tsag_pkg::QCNT_W'(tsag_pkg::QUEUE_DEPTH));
  assign empty   = (oq_count == '0);
  assign oq_pop  = pop && !empty;

  // The whole pipeline moves unless a finished pair has nowhere to go.
  assign adv     = !(v2 && oq_full);
  assign oq_push = adv && v2;
  assign q_pop   = adv && !q_empty;

  always_comb begin
    wet_c      = (wet_amount > tsag_pkg::WET_FULL) ? tsag_pkg::WET_FULL : wet_amount;
    gain_def   = tsag_pkg::UNITY_GAIN - q_data.gain;
    atten_prod = wet_c * gain_def;
    factor     = tsag_pkg::UNITY_GAIN - s1_atten;
    oq_in.left  = tsag_pkg::sat_sample(s2_left);
    oq_in.right = tsag_pkg::sat_sample(s2_right);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= !q_empty;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_left  <= q_data.left;
      s1_right <= q_data.right;
      s1_atten <= atten_prod[tsag_pkg::GAIN_W+tsag_pkg::WET_FRAC-1:tsag_pkg::WET_FRAC];
      s2_left  <= s1_left * $signed({1'b0, factor});
      s2_right <= s1_right * $signed({1'b0, factor});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr] <= oq_in;
    end
  end

  assign left_out  = oq_mem[oq_rd].left;
  assign right_out = oq_mem[oq_rd].right;

endmodule

// ----- hdl/tempo_synced_audio_gate.sv -----
// Tempo-synced stereo gate: configuration registers, front end, queue and back end.
//
// Usage: stereo sample pairs enter through a queue-style port (push, full,
// left_sample, right_sample); a pair is taken at a clock edge with push high
// and full low. Gated pairs leave through empty, pop, left_out and right_out;
// the oldest pair is shown while empty is low and is taken with pop high.
// The six gate registers are written through cfg_write, cfg_index and cfg_data,
// one register per cycle; the user must write them only while no pair is in
// flight, as the block does not enforce this. Each accepted pair yields exactly
// one gated pair, in order, via the middle queue, the attenuation and product
// stages and the result queue. One pair is accepted per cycle while full is low;
// that figure is set by the front end, which updates the gate phase and the
// slewed gain with one add and compare per pair. Up to six pairs can be held
// inside; when the receiver stops popping, the result queue and then the middle
// queue fill and full rises. Synchronous reset loads the register defaults, sets
// the gain to unity and the phase to zero, and empties both queues.
module tempo_synced_audio_gate (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_sample,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_out,
  input  logic                                    cfg_write,
  input  logic [tsag_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tsag_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int MAX_INFLIGHT = 3 * tsag_pkg::QUEUE_DEPTH;

  tsag_pkg::cfg_t cfg;
  tsag_pkg::mid_t fq_data;
  tsag_pkg::mid_t bq_data;
  logic           fq_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic [2:0]     inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beat_phase_step <= tsag_pkg::BEAT_STEP_RESET;
      cfg.rate_mode       <= tsag_pkg::RATE_RESET;
      cfg.rise_step       <= tsag_pkg::SLEW_RESET;
      cfg.fall_step       <= tsag_pkg::SLEW_RESET;
      cfg.wet_amount      <= tsag_pkg::WET_FULL;
      cfg.dip_first       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        tsag_pkg::REG_BEAT_STEP: cfg.beat_phase_step <= cfg_data[tsag_pkg::STEP_W-1:0];
        tsag_pkg::REG_RATE_MODE: cfg.rate_mode       <= cfg_data[tsag_pkg::RATE_W-1:0];
        tsag_pkg::REG_RISE_STEP: cfg.rise_step       <= cfg_data[tsag_pkg::GAIN_W-1:0];
        tsag_pkg::REG_FALL_STEP: cfg.fall_step       <= cfg_data[tsag_pkg::GAIN_W-1:0];
        tsag_pkg::REG_WET:       cfg.wet_amount      <= cfg_data[tsag_pkg::WET_W-1:0];
        tsag_pkg::REG_DIP_FIRST: cfg.dip_first       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tsag_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .q_full       (q_full),
    .q_push       (fq_push),
    .q_data       (fq_data)
  );

  tsag_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (bq_data),
    .empty     (q_empty)
  );

  tsag_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wet_amount (cfg.wet_amount),
    .q_empty    (q_empty),
    .q_data     (bq_data),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .left_out   (left_out),
    .right_out  (right_out)
  );

  assign full = q_full;

  // Number of accepted transactions whose results have not been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if ((push && !full) && !(pop && !empty)) begin
      inflight <= inflight + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      inflight <= inflight - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'(MAX_INFLIGHT))
    else $error("more transactions in flight than the pipeline can hold");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    (inflight == '0) |-> empty)
    else $error("result offered with no transaction in flight");

  a_full_means_backlog: assert property (@(posedge clk) disable iff (rst)
    full |-> (inflight >= 3'(tsag_pkg::QUEUE_DEPTH)))
    else $error("input stalled while the pipeline holds too few transactions");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full && inflight == '0 && !pop) |=> ##3 !empty)
    else $error("result not ready three cycles after an idle accept");
`endif

endmodule

// ----- bench/tempo_synced_audio_gate_checker.sv -----
// Checker for the tempo-synced audio gate: tracks the gate state, predicts each pair, compares.
`timescale 1ns / 100ps

module gate_stream_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  input  logic                                    full,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_sample,
  input  logic                                    empty,
  input  logic                                    pop,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_out,
  input  logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_out,
  input  logic                                    cfg_write,
  input  logic [tsag_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tsag_pkg::CFG_DATA_W-1:0]         cfg_data,
  output int                                      fail_count,
  output int                                      pending
);

  localparam logic [tsag_pkg::RATE_W-1:0]  RATE_QUARTER = tsag_pkg::RATE_W'(1);
  localparam logic [tsag_pkg::RATE_W-1:0]  RATE_32ND    = tsag_pkg::RATE_W'(4);
  localparam logic [tsag_pkg::PHASE_W-1:0] HALF_CYCLE   =
    tsag_pkg::PHASE_W'(1) << (tsag_pkg::PHASE_W - 1);
  localparam longint SAMPLE_MAX = (longint'(1) << (tsag_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // Register copies as the block should hold them.
  logic [tsag_pkg::STEP_W-1:0] beat_step;
  logic [tsag_pkg::RATE_W-1:0] rate;
  logic [tsag_pkg::GAIN_W-1:0] rise;
  logic [tsag_pkg::GAIN_W-1:0] fall;
  logic [tsag_pkg::WET_W-1:0]  wet;
  logic                        dip;

  // Gate state.
  logic [tsag_pkg::PHASE_W-1:0] phase;
  logic [31:0]                  gain;

  tsag_pkg::out_t gated_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic signed [tsag_pkg::SAMPLE_BITS-1:0] scale_sample(
      input logic signed [tsag_pkg::SAMPLE_BITS-1:0] s, input longint factor);
    longint q;
    q = (longint'(s) * factor) >>> tsag_pkg::GAIN_FRAC;
    if (q > SAMPLE_MAX) begin
      q = SAMPLE_MAX;
    end else if (q < SAMPLE_MIN) begin
      q = SAMPLE_MIN;
    end
    return q[tsag_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Advances gain and phase by one sample and returns the gated pair.
  function automatic tsag_pkg::out_t gate_next_pair(
      input logic signed [tsag_pkg::SAMPLE_BITS-1:0] l,
      input logic signed [tsag_pkg::SAMPLE_BITS-1:0] r);
    logic           active;
    logic [31:0]    target;
    longint         wet_eff;
    longint         factor;
    tsag_pkg::out_t res;
    active = (rate >= RATE_QUARTER) && (rate <= RATE_32ND);
    if (!active) begin
      target = tsag_pkg::UNITY_GAIN;
    end else if ((phase < HALF_CYCLE) != dip) begin
      target = tsag_pkg::UNITY_GAIN;
    end else begin
      target = 0;
    end

    // The gain never overshoots its target, whatever the step size.
    if (gain < target) begin
      gain = gain + rise;
      if (gain > target) begin
        gain = target;
      end
    end else if (gain > target) begin
      if (gain - target <= fall) begin
        gain = target;
      end else begin
        gain = gain - fall;
      end
    end

    wet_eff = (wet > tsag_pkg::WET_FULL) ? longint'(tsag_pkg::WET_FULL) : longint'(wet);
    factor  = longint'(tsag_pkg::UNITY_GAIN)
              - ((wet_eff * (longint'(tsag_pkg::UNITY_GAIN) - longint'(gain)))
                 >>> tsag_pkg::WET_FRAC);
    res.left  = scale_sample(l, factor);
    res.right = scale_sample(r, factor);

    if (active) begin
      phase = phase + (tsag_pkg::PHASE_W'(beat_step) << (rate - RATE_QUARTER));
    end else begin
      phase = '0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    tsag_pkg::out_t want;
    if (rst) begin
      beat_step = tsag_pkg::BEAT_STEP_RESET;
      rate      = tsag_pkg::RATE_RESET;
      rise      = tsag_pkg::SLEW_RESET;
      fall      = tsag_pkg::SLEW_RESET;
      wet       = tsag_pkg::WET_FULL;
      dip       = 1'b0;
      phase     = '0;
      gain      = tsag_pkg::UNITY_GAIN;
      gated_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tsag_pkg::REG_BEAT_STEP: beat_step = cfg_data[tsag_pkg::STEP_W-1:0];
          tsag_pkg::REG_RATE_MODE: rate      = cfg_data[tsag_pkg::RATE_W-1:0];
          tsag_pkg::REG_RISE_STEP: rise      = cfg_data[tsag_pkg::GAIN_W-1:0];
          tsag_pkg::REG_FALL_STEP: fall      = cfg_data[tsag_pkg::GAIN_W-1:0];
          tsag_pkg::REG_WET:       wet       = cfg_data[tsag_pkg::WET_W-1:0];
          tsag_pkg::REG_DIP_FIRST: dip       = cfg_data[0];
          default: ;
        endcase
      end

      if (pop && !empty) begin
        if (gated_q.size() == 0) begin
          $error("gated pair popped with no sample pair outstanding");
          fail_count++;
        end else begin
          want = gated_q.pop_front();
          if (left_out !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, left_out);
            fail_count++;
          end
          if (right_out !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, right_out);
            fail_count++;
          end
        end
      end

      if (push && !full) begin
        gated_q.push_back(gate_next_pair(left_sample, right_sample));
      end
    end
    pending <= gated_q.size();
  end

endmodule

// ----- bench/tb_tempo_synced_audio_gate.sv -----
// Testbench top for the tempo-synced audio gate: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_tempo_synced_audio_gate;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES       = 10;
  localparam int PAIRS_PER_PHASE = 80;

  localparam logic [tsag_pkg::RATE_W-1:0]      RATE_OFF     = tsag_pkg::RATE_W'(0);
  localparam logic [tsag_pkg::RATE_W-1:0]      RATE_QUARTER = tsag_pkg::RATE_W'(1);
  localparam logic [tsag_pkg::RATE_W-1:0]      RATE_32ND    = tsag_pkg::RATE_W'(4);
  localparam logic [tsag_pkg::RATE_W-1:0]      RATE_TOP     = tsag_pkg::RATE_W'(7);
  localparam logic [tsag_pkg::STEP_W-1:0]      STEP_MAX     = '1;
  localparam logic [tsag_pkg::GAIN_W-1:0]      SLEW_MAX     = '1;
  localparam logic [tsag_pkg::WET_W-1:0]       WET_MAX      = '1;
  localparam logic [tsag_pkg::CFG_IDX_W-1:0]   SPARE_INDEX  =
    tsag_pkg::CFG_IDX_W'(tsag_pkg::REG_DIP_FIRST) + 1'b1;
  localparam logic [tsag_pkg::SAMPLE_BITS-1:0] SAMPLE_HI    =
    {1'b0, {(tsag_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic [tsag_pkg::SAMPLE_BITS-1:0] SAMPLE_LO    =
    {1'b1, {(tsag_pkg::SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {DRAIN_ALL, POP_COIN, POP_SPARSE, POP_PATTERN} pop_mode_t;

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    push = 1'b0;
  logic                                    full;
  logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_sample = '0;
  logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_sample = '0;
  logic                                    empty;
  logic                                    pop = 1'b0;
  logic signed [tsag_pkg::SAMPLE_BITS-1:0] left_out;
  logic signed [tsag_pkg::SAMPLE_BITS-1:0] right_out;
  logic                                    cfg_write = 1'b0;
  logic [tsag_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
  logic [tsag_pkg::CFG_DATA_W-1:0]         cfg_data = '0;

  int        fail_count;
  int        pending;
  logic      took = 1'b0;
  int        burst_left = 0;
  int        cycle_count = 0;
  pop_mode_t pop_mode = DRAIN_ALL;
  int        pop_mode_left = 0;
  int        pattern_pos = 0;

  tempo_synced_audio_gate dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .left_sample(left_sample), .right_sample(right_sample),
    .empty(empty), .pop(pop), .left_out(left_out), .right_out(right_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gate_stream_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .left_sample(left_sample), .right_sample(right_sample),
    .empty(empty), .pop(pop), .left_out(left_out), .right_out(right_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Records whether the last edge completed an input transaction.
  always @(posedge clk) begin
    took <= push && !full;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: switches at random between stall styles.
  always @(negedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode      <= pop_mode_t'($urandom_range(0, 3));
      pop_mode_left <= $urandom_range(20, 300);
    end else begin
      pop_mode_left <= pop_mode_left - 1;
    end
    pattern_pos <= (pattern_pos + 1) % 7;
    case (pop_mode)
      DRAIN_ALL:  pop <= 1'b1;
      POP_COIN:   pop <= 1'($urandom_range(0, 1));
      POP_SPARSE: pop <= ($urandom_range(0, 9) == 0);
      default:    pop <= (pattern_pos < 3);
    endcase
  end

  function automatic logic [tsag_pkg::SAMPLE_BITS-1:0] extreme_sample(input int k);
    case (k % 4)
      0:       return SAMPLE_LO;
      1:       return SAMPLE_HI;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [tsag_pkg::SAMPLE_BITS-1:0] random_sample();
    if ($urandom_range(0, 7) == 0) begin
      return extreme_sample($urandom_range(0, 3));
    end
    return tsag_pkg::SAMPLE_BITS'($urandom());
  endfunction

  // Sender works in bursts; a zero gap keeps push high across bursts.
  task automatic send_pair(input logic [tsag_pkg::SAMPLE_BITS-1:0] l,
                           input logic [tsag_pkg::SAMPLE_BITS-1:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    push = 1'b1;
    left_sample = l;
    right_sample = r;
    do @(negedge clk); while (!took);
    burst_left--;
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tsag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsag_pkg::CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_setting(input logic [tsag_pkg::STEP_W-1:0] beat,
                               input logic [tsag_pkg::RATE_W-1:0] rate,
                               input logic [tsag_pkg::GAIN_W-1:0] rise,
                               input logic [tsag_pkg::GAIN_W-1:0] fall,
                               input logic [tsag_pkg::WET_W-1:0] wet, input logic dip);
    write_reg(tsag_pkg::REG_BEAT_STEP, tsag_pkg::CFG_DATA_W'(beat));
    write_reg(tsag_pkg::REG_RATE_MODE, tsag_pkg::CFG_DATA_W'(rate));
    write_reg(tsag_pkg::REG_RISE_STEP, tsag_pkg::CFG_DATA_W'(rise));
    write_reg(tsag_pkg::REG_FALL_STEP, tsag_pkg::CFG_DATA_W'(fall));
    write_reg(tsag_pkg::REG_WET, tsag_pkg::CFG_DATA_W'(wet));
    write_reg(tsag_pkg::REG_DIP_FIRST, tsag_pkg::CFG_DATA_W'(dip));
    // Writes to the unused indexes must leave every register alone.
    if ($urandom_range(0, 1) == 1) begin
      write_reg(SPARE_INDEX + tsag_pkg::CFG_IDX_W'($urandom_range(0, 1)),
                tsag_pkg::CFG_DATA_W'($urandom()));
    end
  endtask

  function automatic logic [tsag_pkg::GAIN_W-1:0] random_slew();
    case ($urandom_range(0, 5))
      0:       return tsag_pkg::UNITY_GAIN;
      1:       return tsag_pkg::GAIN_W'($urandom());
      default: return tsag_pkg::GAIN_W'($urandom_range(1 << 16, 1 << 23));
    endcase
  endfunction

  initial begin : stimulus
    int ph;
    int k;
    logic [tsag_pkg::STEP_W-1:0] beat;
    logic [tsag_pkg::RATE_W-1:0] rate;
    logic [tsag_pkg::GAIN_W-1:0] rise;
    logic [tsag_pkg::GAIN_W-1:0] fall;
    logic [tsag_pkg::WET_W-1:0]  wet;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // A few pairs under the reset defaults, then a fast hard gate over the extremes.
    for (k = 0; k < 4; k++) begin
      send_pair(extreme_sample(k), extreme_sample(3 - k));
    end
    wait_drained();
    apply_setting(STEP_MAX, RATE_32ND, tsag_pkg::UNITY_GAIN, tsag_pkg::UNITY_GAIN,
                  tsag_pkg::WET_FULL, 1'b0);
    for (k = 0; k < 20; k++) begin
      send_pair(extreme_sample(k), extreme_sample(k + 1));
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0:       beat = tsag_pkg::STEP_W'(1);
        1:       beat = STEP_MAX;
        default: beat = tsag_pkg::STEP_W'($urandom_range(1 << 20,
                                                         (1 << tsag_pkg::STEP_W) - 1));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        rate = tsag_pkg::RATE_W'($urandom_range(0, 7));
      end else begin
        rate = tsag_pkg::RATE_W'($urandom_range(RATE_QUARTER, RATE_32ND));
      end
      rise = random_slew();
      fall = random_slew();
      case ($urandom_range(0, 3))
        0:       wet = tsag_pkg::WET_FULL;
        1:       wet = tsag_pkg::WET_W'($urandom_range(0, WET_MAX));
        default: wet = tsag_pkg::WET_W'($urandom_range(0, tsag_pkg::WET_FULL));
      endcase
      // The first phases pin the corner settings.
      case (ph)
        0: begin
          beat = STEP_MAX;
          rate = RATE_32ND;
          rise = SLEW_MAX;
          fall = SLEW_MAX;
          wet  = WET_MAX;
        end
        1: begin
          rise = '0;
          fall = '0;
          wet  = '0;
        end
        2: rate = RATE_OFF;
        3: rate = RATE_TOP;
        4: begin
          beat = STEP_MAX;
          rate = RATE_QUARTER;
        end
        default: ;
      endcase
      apply_setting(beat, rate, rise, fall, wet, 1'($urandom_range(0, 1)));
      for (k = 0; k < PAIRS_PER_PHASE; k++) begin
        send_pair(random_sample(), random_sample());
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
